// File: sv/rtmc_pkg.sv
package rtmc_pkg;

    localparam int RANK_W    = 16;
    localparam int TOTAL_W   = 17;
    localparam int GRP_W     = 11;
    localparam int IDX_W     = 10;
    localparam int CFG_IDX_W = 2;
    localparam int CELLS     = RANK_W;
    localparam int DIV_STEPS = TOTAL_W;
    localparam int CNT_W     = 5;

    localparam logic [TOTAL_W-1:0]   MAX_RANKS  = 17'h10000;
    localparam logic [GRP_W-1:0]     MAX_GROUPS = 11'd1024;
    localparam logic [TOTAL_W-1:0]   LIM_NONE   = '1;
    localparam logic [CNT_W-1:0]     DIV_LAST   = 5'(DIV_STEPS - 1);

    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_RANKS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RUN_GROUPS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHAIN_GROUPS = 2'd2;

    typedef enum logic [2:0] {
        ST_LOAD1,
        ST_DIV1,
        ST_MUL1,
        ST_LOAD2,
        ST_DIV2,
        ST_MUL2,
        ST_MUL3,
        ST_IDLE
    } setup_state_t;

    typedef struct packed {
        logic             oor;
        logic             hi;
        logic [IDX_W-1:0] run_idx;
        logic [IDX_W-1:0] base;
    } side_t;

    typedef struct packed {
        logic [TOTAL_W-1:0] rem;
        logic [RANK_W-1:0]  dvd;
        logic [IDX_W-1:0]   quo;
        logic [TOTAL_W-1:0] dvs;
        side_t              side;
    } cell_t;

    typedef struct packed {
        logic [TOTAL_W-1:0] total;
        logic [TOTAL_W-1:0] q1;
        logic [IDX_W-1:0]   r1;
        logic [TOTAL_W-1:0] big1;
        logic [TOTAL_W-1:0] qa;
        logic [IDX_W-1:0]   ra;
        logic [TOTAL_W-1:0] big2a;
        logic [TOTAL_W-1:0] qb;
        logic [IDX_W-1:0]   rb;
        logic [TOTAL_W-1:0] big2b;
    } params_t;

    function automatic logic [GRP_W-1:0] eff_groups(input logic [GRP_W-1:0] g);
        logic [GRP_W-1:0] res;
        if (g == '0)
        begin
            res = GRP_W'(1);
        end
        else if (g > MAX_GROUPS)
        begin
            res = MAX_GROUPS;
        end
        else
        begin
            res = g;
        end
        return res;
    endfunction

endpackage

// File: sv/rtmc_cell.sv
module rtmc_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  rtmc_pkg::cell_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output rtmc_pkg::cell_t out_data
);

    logic                          valid_reg;
    rtmc_pkg::cell_t               data_reg;
    rtmc_pkg::cell_t               data_next;
    logic [rtmc_pkg::TOTAL_W:0]    trial;
    logic [rtmc_pkg::TOTAL_W:0]    diff;
    logic                          ge;

    always_comb
    begin
        trial = {in_data.rem, in_data.dvd[rtmc_pkg::RANK_W-1]};
        ge    = trial >= {1'b0, in_data.dvs};
        diff  = trial - {1'b0, in_data.dvs};
        data_next      = in_data;
        data_next.rem  = ge ? diff[rtmc_pkg::TOTAL_W-1:0] : trial[rtmc_pkg::TOTAL_W-1:0];
        data_next.dvd  = {in_data.dvd[rtmc_pkg::RANK_W-2:0], 1'b0};
        data_next.quo  = {in_data.quo[rtmc_pkg::IDX_W-2:0], ge};
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// File: sv/rtmc_prep.sv
module rtmc_prep (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [rtmc_pkg::RANK_W-1:0]     x,
    input  rtmc_pkg::side_t                 in_side,
    input  logic [rtmc_pkg::TOTAL_W-1:0]    lim,
    input  logic [rtmc_pkg::TOTAL_W-1:0]    big,
    input  logic [rtmc_pkg::TOTAL_W-1:0]    q,
    input  logic [rtmc_pkg::IDX_W-1:0]      r,
    output logic                            out_valid,
    input  logic                            out_ready,
    output rtmc_pkg::cell_t                 out_data
);

    logic                          valid_reg;
    rtmc_pkg::cell_t               data_reg;
    rtmc_pkg::cell_t               data_next;
    logic [rtmc_pkg::TOTAL_W-1:0]  xw;
    logic [rtmc_pkg::TOTAL_W-1:0]  diff;
    logic [rtmc_pkg::TOTAL_W:0]    qp1;
    logic                          lt;

    always_comb
    begin
        xw   = {1'b0, x};
        lt   = xw < big;
        diff = xw - big;
        qp1  = {1'b0, q} + (rtmc_pkg::TOTAL_W+1)'(1);
        data_next.rem          = '0;
        data_next.quo          = '0;
        data_next.dvd          = lt ? x : diff[rtmc_pkg::RANK_W-1:0];
        data_next.dvs          = lt ? qp1[rtmc_pkg::TOTAL_W-1:0] : q;
        data_next.side         = in_side;
        data_next.side.oor     = in_side.oor || (xw >= lim);
        data_next.side.hi      = lt;
        data_next.side.base    = lt ? '0 : r;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// File: sv/rtmc_setup.sv
module rtmc_setup (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [rtmc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rtmc_pkg::TOTAL_W-1:0]      cfg_data,
    output logic                              busy,
    output rtmc_pkg::params_t                 params
);

    rtmc_pkg::setup_state_t          state_reg;
    rtmc_pkg::setup_state_t          state_next;

    logic [rtmc_pkg::TOTAL_W-1:0]    total_reg;
    logic [rtmc_pkg::GRP_W-1:0]      run_reg;
    logic [rtmc_pkg::GRP_W-1:0]      chain_reg;

    logic [rtmc_pkg::TOTAL_W-1:0]    dv_n_reg;
    logic [rtmc_pkg::GRP_W-1:0]      dv_d_reg;
    logic [rtmc_pkg::GRP_W-1:0]      dv_rem_reg;
    logic [rtmc_pkg::TOTAL_W-1:0]    dv_quo_reg;
    logic [rtmc_pkg::CNT_W-1:0]      cnt_reg;

    rtmc_pkg::params_t               par_reg;

    logic [rtmc_pkg::TOTAL_W-1:0]    total_eff;
    logic [rtmc_pkg::GRP_W-1:0]      run_eff;
    logic [rtmc_pkg::GRP_W-1:0]      chain_eff;
    logic [rtmc_pkg::GRP_W:0]        trial;
    logic [rtmc_pkg::GRP_W:0]        trial_diff;
    logic                            ge;
    logic [rtmc_pkg::GRP_W-1:0]      rem_next;
    logic [rtmc_pkg::TOTAL_W-1:0]    quo_next;
    logic                            div_last;
    logic [rtmc_pkg::IDX_W-1:0]      mul_a;
    logic [rtmc_pkg::TOTAL_W-1:0]    mul_b;
    logic [rtmc_pkg::TOTAL_W:0]      mul_b1;
    logic [rtmc_pkg::TOTAL_W+rtmc_pkg::IDX_W:0] prod;
    logic [rtmc_pkg::GRP_W-1:0]      rb_inc;

    always_comb
    begin
        total_eff  = (total_reg > rtmc_pkg::MAX_RANKS) ? rtmc_pkg::MAX_RANKS : total_reg;
        run_eff    = rtmc_pkg::eff_groups(run_reg);
        chain_eff  = rtmc_pkg::eff_groups(chain_reg);
        trial      = {dv_rem_reg, dv_n_reg[rtmc_pkg::TOTAL_W-1]};
        ge         = trial >= {1'b0, dv_d_reg};
        trial_diff = trial - {1'b0, dv_d_reg};
        rem_next   = ge ? trial_diff[rtmc_pkg::GRP_W-1:0] : trial[rtmc_pkg::GRP_W-1:0];
        quo_next   = {dv_quo_reg[rtmc_pkg::TOTAL_W-2:0], ge};
        rb_inc     = {1'b0, par_reg.rb} + rtmc_pkg::GRP_W'(1);
    end

    always_comb
    begin
        unique case (state_reg)
            rtmc_pkg::ST_MUL1:
            begin
                mul_a = par_reg.r1;
                mul_b = par_reg.q1;
            end
            rtmc_pkg::ST_MUL2:
            begin
                mul_a = par_reg.rb;
                mul_b = par_reg.qb;
            end
            default:
            begin
                mul_a = par_reg.ra;
                mul_b = par_reg.qa;
            end
        endcase
        mul_b1 = {1'b0, mul_b} + (rtmc_pkg::TOTAL_W+1)'(1);
        prod   = mul_a * mul_b1;
    end

    always_comb
    begin
        state_next = state_reg;
        if (cfg_we)
        begin
            state_next = rtmc_pkg::ST_LOAD1;
        end
        else
        begin
            unique case (state_reg)
                rtmc_pkg::ST_LOAD1: state_next = rtmc_pkg::ST_DIV1;
                rtmc_pkg::ST_DIV1:  state_next = div_last ? rtmc_pkg::ST_MUL1 : rtmc_pkg::ST_DIV1;
                rtmc_pkg::ST_MUL1:  state_next = rtmc_pkg::ST_LOAD2;
                rtmc_pkg::ST_LOAD2: state_next = rtmc_pkg::ST_DIV2;
                rtmc_pkg::ST_DIV2:  state_next = div_last ? rtmc_pkg::ST_MUL2 : rtmc_pkg::ST_DIV2;
                rtmc_pkg::ST_MUL2:  state_next = rtmc_pkg::ST_MUL3;
                rtmc_pkg::ST_MUL3:  state_next = rtmc_pkg::ST_IDLE;
                rtmc_pkg::ST_IDLE:  state_next = rtmc_pkg::ST_IDLE;
                default:            state_next = rtmc_pkg::ST_LOAD1;
            endcase
        end
    end

    always_comb
    begin
        busy     = (state_reg != rtmc_pkg::ST_IDLE);
        div_last = (cnt_reg == rtmc_pkg::DIV_LAST);
    end

    assign params = par_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rtmc_pkg::ST_LOAD1;
            total_reg <= rtmc_pkg::TOTAL_W'(1);
            run_reg   <= rtmc_pkg::GRP_W'(1);
            chain_reg <= rtmc_pkg::GRP_W'(1);
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    rtmc_pkg::REG_TOTAL_RANKS:  total_reg <= cfg_data;
                    rtmc_pkg::REG_RUN_GROUPS:   run_reg   <= cfg_data[rtmc_pkg::GRP_W-1:0];
                    rtmc_pkg::REG_CHAIN_GROUPS: chain_reg <= cfg_data[rtmc_pkg::GRP_W-1:0];
                    default:                    ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            rtmc_pkg::ST_LOAD1:
            begin
                dv_n_reg      <= total_eff;
                dv_d_reg      <= run_eff;
                dv_rem_reg    <= '0;
                dv_quo_reg    <= '0;
                cnt_reg       <= '0;
                par_reg.total <= total_eff;
            end
            rtmc_pkg::ST_DIV1:
            begin
                dv_n_reg   <= {dv_n_reg[rtmc_pkg::TOTAL_W-2:0], 1'b0};
                dv_rem_reg <= rem_next;
                dv_quo_reg <= quo_next;
                cnt_reg    <= cnt_reg + rtmc_pkg::CNT_W'(1);
                par_reg.q1 <= quo_next;
                par_reg.r1 <= rem_next[rtmc_pkg::IDX_W-1:0];
            end
            rtmc_pkg::ST_MUL1:
            begin
                par_reg.big1 <= prod[rtmc_pkg::TOTAL_W-1:0];
            end
            rtmc_pkg::ST_LOAD2:
            begin
                dv_n_reg   <= par_reg.q1;
                dv_d_reg   <= chain_eff;
                dv_rem_reg <= '0;
                dv_quo_reg <= '0;
                cnt_reg    <= '0;
            end
            rtmc_pkg::ST_DIV2:
            begin
                dv_n_reg   <= {dv_n_reg[rtmc_pkg::TOTAL_W-2:0], 1'b0};
                dv_rem_reg <= rem_next;
                dv_quo_reg <= quo_next;
                cnt_reg    <= cnt_reg + rtmc_pkg::CNT_W'(1);
                par_reg.qb <= quo_next;
                par_reg.rb <= rem_next[rtmc_pkg::IDX_W-1:0];
            end
            rtmc_pkg::ST_MUL2:
            begin
                par_reg.big2b <= prod[rtmc_pkg::TOTAL_W-1:0];
                if (rb_inc == chain_eff)
                begin
                    par_reg.qa <= par_reg.qb + rtmc_pkg::TOTAL_W'(1);
                    par_reg.ra <= '0;
                end
                else
                begin
                    par_reg.qa <= par_reg.qb;
                    par_reg.ra <= rb_inc[rtmc_pkg::IDX_W-1:0];
                end
            end
            rtmc_pkg::ST_MUL3:
            begin
                par_reg.big2a <= prod[rtmc_pkg::TOTAL_W-1:0];
            end
            default:
            begin
            end
        endcase
    end

endmodule

// File: sv/rank_to_mesh_coordinates.sv
// Maps a rank to (run group, chain group, member) under a two-level uneven block
// split. After reset and after every configuration write the block computes group sizes
// with a serial divider, with in_ready low. After that it takes one rank per clock while
// the output is not stalled; each rank passes two rows of 16 divider cells (one quotient
// bit per cell) plus three registered stages; results leave in order with full
// backpressure on either side.
module rank_to_mesh_coordinates (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [rtmc_pkg::RANK_W-1:0]       rank,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [rtmc_pkg::IDX_W-1:0]        run_index,
    output logic [rtmc_pkg::IDX_W-1:0]        chain_index,
    output logic [rtmc_pkg::RANK_W-1:0]       member_index,
    output logic                              out_of_range,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rtmc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rtmc_pkg::TOTAL_W-1:0]      cfg_data
);

    rtmc_pkg::params_t             params;
    logic                          busy;
    logic                          prep1_ready;

    logic [rtmc_pkg::CELLS:0]      l1_valid;
    logic [rtmc_pkg::CELLS:0]      l1_ready;
    rtmc_pkg::cell_t               l1_data [0:rtmc_pkg::CELLS];
    logic [rtmc_pkg::CELLS:0]      l2_valid;
    logic [rtmc_pkg::CELLS:0]      l2_ready;
    rtmc_pkg::cell_t               l2_data [0:rtmc_pkg::CELLS];

    rtmc_pkg::side_t               side1;
    rtmc_pkg::side_t               side2;
    rtmc_pkg::cell_t               last1;
    rtmc_pkg::cell_t               last2;
    logic [rtmc_pkg::TOTAL_W-1:0]  q2;
    logic [rtmc_pkg::IDX_W-1:0]    r2;
    logic [rtmc_pkg::TOTAL_W-1:0]  big2;

    logic                          out_valid_reg;
    logic                          out_take;
    logic [rtmc_pkg::IDX_W-1:0]    run_reg;
    logic [rtmc_pkg::IDX_W-1:0]    chain_reg;
    logic [rtmc_pkg::RANK_W-1:0]   member_reg;
    logic                          oor_reg;

    assign cfg_ready = 1'b1;
    assign in_ready  = prep1_ready && !busy;

    rtmc_setup u_setup (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .busy      (busy),
        .params    (params)
    );

    always_comb
    begin
        side1 = '0;
    end

    rtmc_prep u_prep1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid && !busy),
        .in_ready  (prep1_ready),
        .x         (rank),
        .in_side   (side1),
        .lim       (params.total),
        .big       (params.big1),
        .q         (params.q1),
        .r         (params.r1),
        .out_valid (l1_valid[0]),
        .out_ready (l1_ready[0]),
        .out_data  (l1_data[0])
    );

    for (genvar i = 0; i < rtmc_pkg::CELLS; i++)
    begin : g_l1
        rtmc_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (l1_valid[i]),
            .in_ready  (l1_ready[i]),
            .in_data   (l1_data[i]),
            .out_valid (l1_valid[i+1]),
            .out_ready (l1_ready[i+1]),
            .out_data  (l1_data[i+1])
        );
    end

    always_comb
    begin
        last1           = l1_data[rtmc_pkg::CELLS];
        side2           = last1.side;
        side2.run_idx   = last1.side.base + last1.quo;
        side2.base      = '0;
        q2              = last1.side.hi ? params.qa    : params.qb;
        r2              = last1.side.hi ? params.ra    : params.rb;
        big2            = last1.side.hi ? params.big2a : params.big2b;
    end

    rtmc_prep u_prep2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (l1_valid[rtmc_pkg::CELLS]),
        .in_ready  (l1_ready[rtmc_pkg::CELLS]),
        .x         (last1.rem[rtmc_pkg::RANK_W-1:0]),
        .in_side   (side2),
        .lim       (rtmc_pkg::LIM_NONE),
        .big       (big2),
        .q         (q2),
        .r         (r2),
        .out_valid (l2_valid[0]),
        .out_ready (l2_ready[0]),
        .out_data  (l2_data[0])
    );

    for (genvar i = 0; i < rtmc_pkg::CELLS; i++)
    begin : g_l2
        rtmc_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (l2_valid[i]),
            .in_ready  (l2_ready[i]),
            .in_data   (l2_data[i]),
            .out_valid (l2_valid[i+1]),
            .out_ready (l2_ready[i+1]),
            .out_data  (l2_data[i+1])
        );
    end

    assign last2                    = l2_data[rtmc_pkg::CELLS];
    assign out_take                 = !out_valid_reg || out_ready;
    assign l2_ready[rtmc_pkg::CELLS] = out_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_take)
        begin
            out_valid_reg <= l2_valid[rtmc_pkg::CELLS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_take && l2_valid[rtmc_pkg::CELLS])
        begin
            oor_reg <= last2.side.oor;
            if (last2.side.oor)
            begin
                run_reg    <= '0;
                chain_reg  <= '0;
                member_reg <= '0;
            end
            else
            begin
                run_reg    <= last2.side.run_idx;
                chain_reg  <= last2.side.base + last2.quo;
                member_reg <= last2.rem[rtmc_pkg::RANK_W-1:0];
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign run_index    = run_reg;
    assign chain_index  = chain_reg;
    assign member_index = member_reg;
    assign out_of_range = oor_reg;

endmodule

// File: sv/rtmc_checker.sv
module rtmc_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic [rtmc_pkg::IDX_W-1:0]        run_index,
    input logic [rtmc_pkg::IDX_W-1:0]        chain_index,
    input logic [rtmc_pkg::RANK_W-1:0]       member_index,
    input logic                              out_of_range,
    input logic                              cfg_valid,
    input logic                              cfg_ready
);

    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_of_range |-> run_index == '0 && chain_index == '0
                                      && member_index == '0)
        else $error("out of range result carries coordinates");

    a_cfg_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> !in_ready)
        else $error("input taken right after configuration write");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(run_index)
                                    && $stable(chain_index) && $stable(member_index))
        else $error("stalled result changed");

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid)
        else $error("input transaction withdrawn before accept");

    a_reset_busy: assert property (@(posedge clk)
        !rst_n |=> !in_ready)
        else $error("input ready during setup after reset");

endmodule

bind rank_to_mesh_coordinates rtmc_checker u_rtmc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .run_index    (run_index),
    .chain_index  (chain_index),
    .member_index (member_index),
    .out_of_range (out_of_range),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready)
);
